// ----- sv/itp_pkg.sv -----
`default_nettype none

package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_ADD = 8'h2B;
   localparam logic [7:0] CHAR_SUB = 8'h2D;
   localparam logic [7:0] CHAR_MUL = 8'h2A;
   localparam logic [7:0] CHAR_DIV = 8'h2F;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      BK_EVAL,
      BK_FLUSH,
      BK_END
   } back_state_type;

   typedef struct packed {
      logic [7:0]  symbol;
      logic        is_op;
      op_code_type code;
      logic        expr_end;
   } item_type;

   typedef struct packed {
      logic [7:0] out_symbol;
      logic       run_last;
      logic       expr_done;
      logic       dropped;
   } result_type;

   function automatic logic op_prec_high(input op_code_type code);
      logic hi;
      hi = (code == OP_MUL) || (code == OP_DIV);
      return hi;
   endfunction

   function automatic logic [7:0] op_char(input op_code_type code);
      logic [7:0] c;
      unique case (code)
         OP_ADD: c = CHAR_ADD;
         OP_SUB: c = CHAR_SUB;
         OP_MUL: c = CHAR_MUL;
         OP_DIV: c = CHAR_DIV;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- sv/itp_front.sv -----
`default_nettype none

module itp_front
   import itp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_expr_end,
   output logic            q_valid,
   output item_type        q_head,
   input  wire logic       q_pop
);

   item_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   item_type            item;
   logic                accept;

   // classify the incoming character
   always_comb begin
      item.symbol   = req_symbol;
      item.expr_end = req_expr_end;
      item.is_op    = 1'b1;
      unique case (req_symbol)
         CHAR_ADD: item.code = OP_ADD;
         CHAR_SUB: item.code = OP_SUB;
         CHAR_MUL: item.code = OP_MUL;
         CHAR_DIV: item.code = OP_DIV;
         default: begin
            item.code  = OP_ADD;
            item.is_op = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_head    = queue_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (accept) begin
         tail_in = tail_ff + QPTR_W'(1);
      end
      if (q_pop && q_valid) begin
         head_in = head_ff + QPTR_W'(1);
      end
      if (accept && !(q_pop && q_valid)) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!accept && q_pop && q_valid) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[tail_ff] <= item;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (accept && !q_pop) |=> q_valid)
      else $error("accepted transaction lost from queue");
`endif

endmodule

`default_nettype wire

// ----- sv/itp_back.sv -----
`default_nettype none

module itp_back
   import itp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire item_type   q_head,
   output logic            q_pop,
   output logic            res_valid,
   output result_type      res,
   input  wire logic       res_ready
);

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   op_code_type       stack_ff [STACK_DEPTH];
   logic [7:0]        hold_sym_ff, hold_sym_in;
   logic              hold_drop_ff, hold_drop_in;
   logic              hold_valid_ff, hold_valid_in;

   logic [CNT_W-1:0]  cnt_m1;
   logic [IDX_W-1:0]  top_idx;
   logic [IDX_W-1:0]  push_idx;
   op_code_type       top_code;
   logic              push_en;
   logic              em_valid;
   logic [7:0]        em_sym;
   logic              em_drop;
   logic              can_emit;

   assign cnt_m1   = count_ff - CNT_W'(1);
   assign top_idx  = cnt_m1[IDX_W-1:0];
   assign push_idx = count_ff[IDX_W-1:0];
   assign top_code = stack_ff[top_idx];
   assign can_emit = !hold_valid_ff || res_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      hold_sym_in   = hold_sym_ff;
      hold_drop_in  = hold_drop_ff;
      hold_valid_in = hold_valid_ff;
      push_en       = 1'b0;
      q_pop         = 1'b0;
      res_valid     = 1'b0;
      res           = '0;
      em_valid      = 1'b0;
      em_sym        = '0;
      em_drop       = 1'b0;

      unique case (state_ff)
         BK_EVAL: begin
            if (q_valid) begin
               if (!q_head.is_op) begin
                  em_valid = 1'b1;
                  em_sym   = q_head.symbol;
                  if (can_emit) begin
                     state_in = q_head.expr_end ? BK_FLUSH : BK_END;
                  end
               end else if (count_ff != '0 &&
                            (op_prec_high(top_code) || !op_prec_high(q_head.code))) begin
                  em_valid = 1'b1;
                  em_sym   = op_char(top_code);
                  if (can_emit) begin
                     count_in = cnt_m1;
                  end
               end else if (count_ff == CNT_W'(STACK_DEPTH)) begin
                  em_valid = 1'b1;
                  em_sym   = q_head.symbol;
                  em_drop  = 1'b1;
                  if (can_emit) begin
                     state_in = q_head.expr_end ? BK_FLUSH : BK_END;
                  end
               end else begin
                  push_en  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  state_in = q_head.expr_end ? BK_FLUSH : BK_END;
               end
            end
         end
         BK_FLUSH: begin
            if (count_ff != '0) begin
               em_valid = 1'b1;
               em_sym   = op_char(top_code);
               if (can_emit) begin
                  count_in = cnt_m1;
               end
            end else begin
               state_in = BK_END;
            end
         end
         BK_END: begin
            if (!hold_valid_ff) begin
               q_pop    = 1'b1;
               state_in = BK_EVAL;
            end else if (res_ready) begin
               res_valid      = 1'b1;
               res.out_symbol = hold_sym_ff;
               res.dropped    = hold_drop_ff;
               res.run_last   = 1'b1;
               res.expr_done  = q_head.expr_end;
               hold_valid_in  = 1'b0;
               q_pop          = 1'b1;
               state_in       = BK_EVAL;
            end
         end
         default: begin
            state_in = BK_EVAL;
         end
      endcase

      // a new emission pushes the held one out, not yet known to be the last
      if (em_valid && can_emit) begin
         if (hold_valid_ff) begin
            res_valid      = 1'b1;
            res.out_symbol = hold_sym_ff;
            res.dropped    = hold_drop_ff;
         end
         hold_sym_in   = em_sym;
         hold_drop_in  = em_drop;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_EVAL;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_sym_ff  <= hold_sym_in;
      hold_drop_ff <= hold_drop_in;
      if (push_en) begin
         stack_ff[push_idx] <= q_head.code;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("operator stack overflow");
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res_ready)
      else $error("result issued without a free output slot");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_END && q_valid))
      else $error("transaction retired outside the end step");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !hold_valid_ff)
      else $error("held result left behind after transaction end");
`endif

endmodule

`default_nettype wire

// ----- sv/infix_to_postfix_converter_top.sv -----
// an operand result goes from the queue through the hold register into the output register
// an operator first pops each stacked operator of equal or higher precedence, then is pushed
// a final character also flushes the stack; one pop a cycle unless the output stalls
// a 2-entry queue lets the input side keep accepting while the stack engine is busy
// reset: synchronous, active high; empties queue, stack and output register
`default_nettype none

module infix_to_postfix_converter_top
   import itp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_expr_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_symbol,
   output logic            rsp_run_last,
   output logic            rsp_expr_done,
   output logic            rsp_dropped
);

   logic       q_valid;
   item_type   q_head;
   logic       q_pop;
   logic       res_valid;
   result_type res;
   logic       out_free;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   itp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_symbol   (req_symbol),
      .req_expr_end (req_expr_end),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop)
   );

   itp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (out_free)
   );

   // output register, loaded when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_symbol = rsp_data_ff.out_symbol;
   assign rsp_run_last   = rsp_data_ff.run_last;
   assign rsp_expr_done  = rsp_data_ff.expr_done;
   assign rsp_dropped    = rsp_data_ff.dropped;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expr_done |-> rsp_run_last)
      else $error("expression end without transaction end");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_out_symbol == CHAR_ADD || rsp_out_symbol == CHAR_SUB
         || rsp_out_symbol == CHAR_MUL || rsp_out_symbol == CHAR_DIV)
      else $error("dropped flag on a non-operator");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result lost");
`endif

endmodule

`default_nettype wire
